/* rtl/core/rec_pkg.sv */
`default_nettype none

package rec_pkg;

  // Default timing constants, in milliseconds.
  localparam int unsigned VelIntervalMs = 50;
  localparam int unsigned ArmHoldTimeMs = 150;
  localparam int unsigned PulseTimeMs   = 5000;

  // Field widths.
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HeightW = 24;
  localparam int unsigned VelW    = 20;
  localparam int unsigned AccelW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // The height change magnitude is below 2^24 and times 1000 stays below 2^34.
  localparam int unsigned DiffMagW = HeightW;
  localparam int unsigned ScaleW   = 10;
  localparam int unsigned ProdW    = DiffMagW + ScaleW;
  localparam int unsigned DivCntW  = $clog2(ProdW + 1);
  localparam logic [ScaleW-1:0] VelScale = ScaleW'(1000);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GROUND_ALT  = 3'd0,
    CFG_ARM_HEIGHT  = 3'd1,
    CFG_ARM_VEL     = 3'd2,
    CFG_ARM_ACCEL   = 3'd3,
    CFG_EJECT_HGT   = 3'd4,
    CFG_EJECT_VEL   = 3'd5,
    CFG_EJECT_ACCEL = 3'd6,
    CFG_FAILSAFE    = 3'd7
  } cfg_idx_e;

  // Flight phase as reported on the result.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_DONE  = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEIGHT,
    ST_PROD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_VEL,
    ST_EVAL
  } ctrl_state_e;

  typedef struct packed {
    logic [TimeW-1:0]          time_ms;
    logic signed [HeightW-1:0] altitude_raw;
    logic [AccelW-1:0]         accel_magnitude;
  } in_beat_t;

  typedef struct packed {
    logic                   pyro_on;
    logic                   armed_flag;
    logic                   done_res;
    logic [1:0]             phase;
    logic signed [VelW-1:0] velocity_est;
  } out_beat_t;

  typedef struct packed {
    logic load_in;
    logic calc_height;
    logic calc_prod;
    logic div_start;
    logic vel_write;
    logic eval;
  } dp_cmd_t;

  typedef struct packed {
    logic vel_update;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rec_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rec_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rec_pkg::ProdW-1:0]   dividend_i,
  input  wire logic [rec_pkg::TimeW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rec_pkg::ProdW-1:0]        quotient_o
);

  logic [rec_pkg::ProdW-1:0]   quo_q, quo_d;
  logic [rec_pkg::TimeW-1:0]   rem_q, rem_d;
  logic [rec_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [rec_pkg::TimeW:0]     rem_sh;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[rec_pkg::ProdW-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = rec_pkg::DivCntW'(rec_pkg::ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[rec_pkg::ProdW-2:0], ge};
      rem_d = ge ? rec_pkg::TimeW'(rem_sh - {1'b0, divisor_i}) : rem_sh[rec_pkg::TimeW-1:0];
      cnt_d = cnt_q - rec_pkg::DivCntW'(1);
      if (cnt_q == rec_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/rec_dp.sv */
`default_nettype none

// Datapath: configuration, flight state, velocity estimate and result register.
module rec_dp #(
  parameter int unsigned VEL_INTERVAL_MS  = rec_pkg::VelIntervalMs,
  parameter int unsigned ARM_HOLD_TIME_MS = rec_pkg::ArmHoldTimeMs,
  parameter int unsigned PULSE_TIME_MS    = rec_pkg::PulseTimeMs
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rec_pkg::dp_cmd_t              cmd_i,
  output rec_pkg::dp_stat_t                  stat_o,
  input  wire rec_pkg::in_beat_t             in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rec_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rec_pkg::CfgW-1:0]      cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rec_pkg::out_beat_t                 out_data_o
);

  localparam int unsigned TW = rec_pkg::TimeW;
  localparam int unsigned HW = rec_pkg::HeightW;
  localparam int unsigned VW = rec_pkg::VelW;
  localparam int unsigned AW = rec_pkg::AccelW;

  // Configuration registers.
  logic signed [HW-1:0] ground_q, arm_height_q, eject_height_q;
  logic signed [VW-1:0] arm_vel_q, eject_vel_q;
  logic [AW-1:0]        arm_accel_q, eject_accel_q;
  logic [TW-1:0]        failsafe_q;

  // Flight state.
  logic                 started_q, started_d;
  logic [TW-1:0]        last_time_q, last_time_d;
  logic signed [HW-1:0] last_height_q;
  logic signed [VW-1:0] velocity_q;
  rec_pkg::mode_e       mode_q, mode_d;
  logic                 hold_active_q, hold_active_d;
  logic [TW-1:0]        hold_start_q, hold_start_d;
  logic [TW-1:0]        arm_time_q, arm_time_d;
  logic [TW-1:0]        pulse_start_q, pulse_start_d;

  // Per-sample working registers.
  rec_pkg::in_beat_t           in_q;
  logic signed [HW-1:0]        height_q;
  logic [TW-1:0]               dt_q;
  logic [rec_pkg::ProdW-1:0]   prod_q;
  logic                        neg_q;

  // Result register.
  logic               out_valid_q;
  rec_pkg::out_beat_t out_q, out_d;

  logic signed [HW:0]         alt_diff;
  logic signed [HW-1:0]       height_sat;
  logic signed [HW:0]         h_diff;
  logic [HW-1:0]              h_mag;
  logic                       div_done;
  logic [rec_pkg::ProdW-1:0]  quotient;
  logic signed [VW-1:0]       vel_sat;
  logic                       arm_cond, hold_ok, eject_cond;
  logic [TW-1:0]              now, hold_ref;

  assign now = in_q.time_ms;

  // Height with saturation to the signed 24-bit range.
  always_comb begin
    alt_diff = {in_q.altitude_raw[HW-1], in_q.altitude_raw} - {ground_q[HW-1], ground_q};
    if (alt_diff[HW] != alt_diff[HW-1]) begin
      height_sat = alt_diff[HW] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    end else begin
      height_sat = alt_diff[HW-1:0];
    end
  end

  // Height change magnitude and sign.
  always_comb begin
    h_diff = {height_q[HW-1], height_q} - {last_height_q[HW-1], last_height_q};
    h_mag  = h_diff[HW] ? HW'(-h_diff) : h_diff[HW-1:0];
  end

  rec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Apply sign and saturate to the signed 20-bit range.
  always_comb begin
    if (!neg_q) begin
      if (quotient > rec_pkg::ProdW'((1 << (VW-1)) - 1)) begin
        vel_sat = {1'b0, {(VW-1){1'b1}}};
      end else begin
        vel_sat = quotient[VW-1:0];
      end
    end else begin
      if (quotient > rec_pkg::ProdW'(1 << (VW-1))) begin
        vel_sat = {1'b1, {(VW-1){1'b0}}};
      end else begin
        vel_sat = VW'(-quotient[VW-1:0]);
      end
    end
  end

  // Arming, ejection and pulse decisions on the current sample.
  always_comb begin
    started_d     = started_q;
    last_time_d   = last_time_q;
    mode_d        = mode_q;
    hold_active_d = hold_active_q;
    hold_start_d  = hold_start_q;
    arm_time_d    = arm_time_q;
    pulse_start_d = pulse_start_q;
    hold_ref      = hold_active_q ? hold_start_q : now;
    arm_cond      = (height_q > arm_height_q) && (velocity_q > arm_vel_q)
                    && (in_q.accel_magnitude > arm_accel_q);
    hold_ok       = (now - hold_ref) > TW'(ARM_HOLD_TIME_MS);
    eject_cond    = (velocity_q < eject_vel_q) && (height_q >= eject_height_q)
                    && (in_q.accel_magnitude < eject_accel_q);

    if (!started_q) begin
      started_d   = 1'b1;
      last_time_d = now;
    end

    if (mode_q == rec_pkg::MODE_IDLE) begin
      if (arm_cond) begin
        hold_active_d = 1'b1;
        hold_start_d  = hold_ref;
        if (hold_ok) begin
          mode_d     = rec_pkg::MODE_ARMED;
          arm_time_d = now;
        end
      end else begin
        hold_active_d = 1'b0;
      end
    end

    if (mode_d == rec_pkg::MODE_ARMED) begin
      // Either the nominal apogee condition or the failsafe timeout starts the pulse.
      if (eject_cond || ((now - arm_time_d) > failsafe_q)) begin
        mode_d        = rec_pkg::MODE_PULSE;
        pulse_start_d = now;
      end
    end else if (mode_d == rec_pkg::MODE_PULSE) begin
      if ((now - pulse_start_q) >= TW'(PULSE_TIME_MS)) begin
        mode_d = rec_pkg::MODE_DONE;
      end
    end

    out_d.pyro_on      = mode_d == rec_pkg::MODE_PULSE;
    out_d.armed_flag   = mode_d != rec_pkg::MODE_IDLE;
    out_d.done_res     = mode_d == rec_pkg::MODE_DONE;
    out_d.phase        = mode_d;
    out_d.velocity_est = velocity_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ground_q       <= '0;
      arm_height_q   <= HW'(160);
      arm_vel_q      <= VW'(320);
      arm_accel_q    <= AW'(800);
      eject_height_q <= HW'(15200);
      eject_vel_q    <= VW'(96);
      eject_accel_q  <= AW'(480);
      failsafe_q     <= TW'(14000);
    end else if (cfg_we_i) begin
      case (rec_pkg::cfg_idx_e'(cfg_index_i))
        rec_pkg::CFG_GROUND_ALT:  ground_q       <= cfg_data_i[HW-1:0];
        rec_pkg::CFG_ARM_HEIGHT:  arm_height_q   <= cfg_data_i[HW-1:0];
        rec_pkg::CFG_ARM_VEL:     arm_vel_q      <= cfg_data_i[VW-1:0];
        rec_pkg::CFG_ARM_ACCEL:   arm_accel_q    <= cfg_data_i[AW-1:0];
        rec_pkg::CFG_EJECT_HGT:   eject_height_q <= cfg_data_i[HW-1:0];
        rec_pkg::CFG_EJECT_VEL:   eject_vel_q    <= cfg_data_i[VW-1:0];
        rec_pkg::CFG_EJECT_ACCEL: eject_accel_q  <= cfg_data_i[AW-1:0];
        rec_pkg::CFG_FAILSAFE:    failsafe_q     <= cfg_data_i[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      last_time_q   <= '0;
      last_height_q <= '0;
      velocity_q    <= '0;
      mode_q        <= rec_pkg::MODE_IDLE;
      hold_active_q <= 1'b0;
      hold_start_q  <= '0;
      arm_time_q    <= '0;
      pulse_start_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.vel_write) begin
        velocity_q    <= vel_sat;
        last_height_q <= height_q;
        last_time_q   <= now;
      end
      if (cmd_i.eval) begin
        started_q     <= started_d;
        if (!started_q) begin
          last_time_q <= last_time_d;
        end
        mode_q        <= mode_d;
        hold_active_q <= hold_active_d;
        hold_start_q  <= hold_start_d;
        arm_time_q    <= arm_time_d;
        pulse_start_q <= pulse_start_d;
      end
      if (cmd_i.eval) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.calc_height) begin
      height_q <= height_sat;
      dt_q     <= now - last_time_q;
    end
    if (cmd_i.calc_prod) begin
      prod_q <= h_mag * rec_pkg::VelScale;
      neg_q  <= h_diff[HW];
    end
    if (cmd_i.eval) begin
      out_q <= out_d;
    end
  end

  assign stat_o.vel_update = started_q && (dt_q >= TW'(VEL_INTERVAL_MS));
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

/* rtl/core/rec_ctrl.sv */
`default_nettype none

// Sequencer that steps one sample through the datapath.
module rec_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rec_pkg::dp_stat_t stat_i,
  output rec_pkg::dp_cmd_t       cmd_o
);

  rec_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rec_pkg::ST_IDLE:      if (in_valid_i) state_d = rec_pkg::ST_HEIGHT;
      rec_pkg::ST_HEIGHT:    state_d = rec_pkg::ST_PROD;
      rec_pkg::ST_PROD: begin
        state_d = stat_i.vel_update ? rec_pkg::ST_DIV_START : rec_pkg::ST_EVAL;
      end
      rec_pkg::ST_DIV_START: state_d = rec_pkg::ST_DIV_WAIT;
      rec_pkg::ST_DIV_WAIT:  if (stat_i.div_done) state_d = rec_pkg::ST_VEL;
      rec_pkg::ST_VEL:       state_d = rec_pkg::ST_EVAL;
      rec_pkg::ST_EVAL:      if (stat_i.out_free) state_d = rec_pkg::ST_IDLE;
      default:               state_d = rec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      rec_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      rec_pkg::ST_HEIGHT:    cmd_o.calc_height = 1'b1;
      rec_pkg::ST_PROD:      cmd_o.calc_prod   = 1'b1;
      rec_pkg::ST_DIV_START: cmd_o.div_start   = 1'b1;
      rec_pkg::ST_VEL:       cmd_o.vel_write   = 1'b1;
      rec_pkg::ST_EVAL:      cmd_o.eval        = stat_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/recovery_ejection_controller_core.sv */
`default_nettype none

// Channel   Direction  Signals                               Beat
// --------  ---------  ------------------------------------  ----------------------------
// in        input      in_valid_i / in_ready_o / in_data_i   one sensor sample
// out       output     out_valid_o / out_ready_i / out_data_o one status result per sample
// cfg       input      cfg_valid_i / cfg_ready_o / cfg_index_i, cfg_data_i  one register write
//
// A sample without a velocity update goes from acceptance through the height and
// product steps to evaluation, which loads the result register. A sample that
// updates the velocity also starts the divider, waits for it and writes the
// velocity before evaluation: the quotient comes from a restoring divider
// that produces one bit per cycle over 34 bits.
// One sample is worked on at a time; the next beat is accepted as soon as the
// result has been moved into the output register, even if that result still
// waits. A stalled output holds the sequencer before that move. Reset returns
// the flight state to idle and the configuration to its defaults; there is no
// clearing pass. The configuration port is always ready.
module recovery_ejection_controller_core #(
  parameter int unsigned VEL_INTERVAL_MS  = rec_pkg::VelIntervalMs,
  parameter int unsigned ARM_HOLD_TIME_MS = rec_pkg::ArmHoldTimeMs,
  parameter int unsigned PULSE_TIME_MS    = rec_pkg::PulseTimeMs
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rec_pkg::in_beat_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rec_pkg::out_beat_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rec_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rec_pkg::CfgW-1:0]      cfg_data_i
);

  rec_pkg::dp_cmd_t  cmd;
  rec_pkg::dp_stat_t stat;

  // The user must send register writes only while no sample is in flight; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  rec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rec_dp #(
    .VEL_INTERVAL_MS  (VEL_INTERVAL_MS),
    .ARM_HOLD_TIME_MS (ARM_HOLD_TIME_MS),
    .PULSE_TIME_MS    (PULSE_TIME_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_recovery_ejection_controller_core.sv */
`default_nettype none

// Self-checking bench for the recovery ejection controller.
//
// Every sample beat that the block accepts is also run through a local
// predictor of the flight logic, and the predicted status is queued. Each
// result beat is checked field by field against the oldest queued status.
// The flight state only moves forward (idle, armed, pulse, done), and reset is
// applied once. So the run keeps arming out of reach for most of its length
// and flies one full profile at the very end.
module tb_recovery_ejection_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rec_pkg::*;

  // Far above the slowest correct run: at most some 1200 samples, plus register
  // writes and one long output stall.
  localparam int unsigned CycleLimit = 600000;

  localparam longint HeightMax = (longint'(1) <<< (HeightW - 1)) - 1;
  localparam longint HeightMin = -(longint'(1) <<< (HeightW - 1));
  localparam longint VelMax    = (longint'(1) <<< (VelW - 1)) - 1;
  localparam longint VelMin    = -(longint'(1) <<< (VelW - 1));

  // The three ways the final flight can end.
  typedef enum logic [1:0] {
    FLIGHT_APOGEE,
    FLIGHT_FAILSAFE,
    FLIGHT_INSTANT
  } flight_kind_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  in_beat_t             in_data   = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgW-1:0]      cfg_data  = '0;

  // Register copies used by the predictor, starting at the reset defaults.
  logic signed [HeightW-1:0] cfg_ground   = '0;
  logic signed [HeightW-1:0] cfg_arm_h    = 24'sd160;
  logic signed [VelW-1:0]    cfg_arm_v    = 20'sd320;
  logic [AccelW-1:0]         cfg_arm_a    = 16'd800;
  logic signed [HeightW-1:0] cfg_eject_h  = 24'sd15200;
  logic signed [VelW-1:0]    cfg_eject_v  = 20'sd96;
  logic [AccelW-1:0]         cfg_eject_a  = 16'd480;
  logic [TimeW-1:0]          cfg_failsafe = 32'd14000;

  // Flight state copies, starting at the reset values.
  logic                      seen_first = 1'b0;
  logic [TimeW-1:0]          ref_time   = '0;
  logic signed [HeightW-1:0] ref_height = '0;
  logic signed [VelW-1:0]    vel_est    = '0;
  mode_e                     phase_q    = MODE_IDLE;
  logic                      hold_on    = 1'b0;
  logic [TimeW-1:0]          hold_t0    = '0;
  logic [TimeW-1:0]          armed_t0   = '0;
  logic [TimeW-1:0]          pulse_t0   = '0;

  out_beat_t status_expected[$];
  int        mismatch_count = 0;

  // Handshake pacing shared by the sender and the receiver. While
  // no_gap_run is nonzero neither side idles. sink_hold_cycles is a long
  // hold-off that the receiver counts down on its own.
  int          no_gap_run       = 0;
  int          sink_wait        = 0;
  int          sink_hold_cycles = 0;
  logic [31:0] now_ms           = '0;

  recovery_ejection_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicts the status beat for one sample and advances the local state.
  function automatic out_beat_t predict_status(in_beat_t s);
    out_beat_t        r;
    longint           height;
    longint           acc;
    longint           q;
    logic [TimeW-1:0] dt;
    acc = longint'(s.accel_magnitude);
    height = longint'($signed(s.altitude_raw)) - longint'(cfg_ground);
    if (height > HeightMax) height = HeightMax;
    if (height < HeightMin) height = HeightMin;

    // The first sample only sets the time reference; the height reference
    // stays at ground level.
    if (!seen_first) begin
      seen_first = 1'b1;
      ref_time = s.time_ms;
    end else begin
      dt = s.time_ms - ref_time;
      if (dt >= VelIntervalMs) begin
        q = ((height - longint'(ref_height)) * 1000) / longint'(dt);
        if (q > VelMax) q = VelMax;
        if (q < VelMin) q = VelMin;
        vel_est = VelW'(q);
        ref_height = HeightW'(height);
        ref_time = s.time_ms;
      end
    end

    if (phase_q == MODE_IDLE) begin
      if (height > longint'(cfg_arm_h) && vel_est > cfg_arm_v &&
          acc > longint'(cfg_arm_a)) begin
        if (!hold_on) begin
          hold_on = 1'b1;
          hold_t0 = s.time_ms;
        end
        if (TimeW'(s.time_ms - hold_t0) > ArmHoldTimeMs) begin
          phase_q = MODE_ARMED;
          armed_t0 = s.time_ms;
        end
      end else begin
        hold_on = 1'b0;
      end
    end

    // The armed checks also run on the sample that arms; the apogee
    // condition wins over the failsafe timer.
    if (phase_q == MODE_ARMED) begin
      if (vel_est < cfg_eject_v && height >= longint'(cfg_eject_h) &&
          acc < longint'(cfg_eject_a)) begin
        phase_q = MODE_PULSE;
        pulse_t0 = s.time_ms;
      end else if (TimeW'(s.time_ms - armed_t0) > cfg_failsafe) begin
        phase_q = MODE_PULSE;
        pulse_t0 = s.time_ms;
      end
    end else if (phase_q == MODE_PULSE) begin
      if (TimeW'(s.time_ms - pulse_t0) >= PulseTimeMs) phase_q = MODE_DONE;
    end

    r.pyro_on      = (phase_q == MODE_PULSE);
    r.armed_flag   = (phase_q != MODE_IDLE);
    r.done_res     = (phase_q == MODE_DONE);
    r.phase        = phase_q;
    r.velocity_est = vel_est;
    return r;
  endfunction

  // Offers one sample beat and queues its predicted status once accepted.
  // It is entered just after a rising edge and returns just after the edge
  // that accepted the beat, so valid can stay high into the next beat.
  task automatic send_sample(input logic [TimeW-1:0] t,
                             input logic signed [HeightW-1:0] alt,
                             input logic [AccelW-1:0] acc);
    int       gap;
    in_beat_t s;
    if (no_gap_run > 0) no_gap_run--;
    else if ($urandom_range(0, 39) == 0) no_gap_run = $urandom_range(10, 40);
    gap = (no_gap_run > 0) ? 0 : $urandom_range(0, 6);
    s.time_ms = t;
    s.altitude_raw = alt;
    s.accel_magnitude = acc;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk_i); while (!in_ready);
    status_expected.push_back(predict_status(s));
  endtask

  // Drops valid and waits until every queued status has come back, so that
  // the block is idle before a register write.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_GROUND_ALT:  cfg_ground   = value[HeightW-1:0];
      CFG_ARM_HEIGHT:  cfg_arm_h    = value[HeightW-1:0];
      CFG_ARM_VEL:     cfg_arm_v    = value[VelW-1:0];
      CFG_ARM_ACCEL:   cfg_arm_a    = value[AccelW-1:0];
      CFG_EJECT_HGT:   cfg_eject_h  = value[HeightW-1:0];
      CFG_EJECT_VEL:   cfg_eject_v  = value[VelW-1:0];
      CFG_EJECT_ACCEL: cfg_eject_a  = value[AccelW-1:0];
      CFG_FAILSAFE:    cfg_failsafe = value;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Default registers. The first sample, the 50 ms velocity interval at and
  // below its edge, truncation toward zero, velocity saturation at both ends,
  // an arming hold that starts and breaks, and a zero time step.
  task automatic test_first_sample_and_velocity();
    send_sample(32'd1000, 24'sd500, 16'd0);
    send_sample(32'd1020, 24'sd600, 16'd0);
    send_sample(32'd1050, 24'sd700, 16'd0);
    send_sample(32'd1099, 24'sd100, 16'd0);
    send_sample(32'd1150, -24'sd300, 16'd0);
    send_sample(32'd1203, -24'sd307, 16'd0);
    send_sample(32'd1230, -24'sd307, 16'hFFFF);
    send_sample(32'd1300, 24'sh7FFFFF, 16'd0);
    send_sample(32'd1310, 24'sh7FFFFF, 16'hFFFF);
    send_sample(32'd1320, 24'sh7FFFFF, 16'd0);
    send_sample(32'd1400, 24'sh800000, 16'd0);
    send_sample(32'd1400, 24'sh800000, 16'd0);
    now_ms = 32'd1400;
  endtask

  // Ground altitude at both extremes pushes the height past the 24-bit range
  // in both directions. Arming is put out of reach first: no acceleration
  // can exceed the largest threshold.
  task automatic test_height_saturation();
    drain_results();
    write_reg(CFG_ARM_ACCEL, 32'h0000_FFFF);
    write_reg(CFG_ARM_HEIGHT, 32'h007F_FFFF);
    write_reg(CFG_ARM_VEL, 32'h0007_FFFF);
    write_reg(CFG_EJECT_HGT, 32'h0080_0000);
    write_reg(CFG_EJECT_VEL, 32'h0008_0000);
    write_reg(CFG_EJECT_ACCEL, 32'h0000_0000);
    write_reg(CFG_FAILSAFE, 32'h0000_0000);
    write_reg(CFG_GROUND_ALT, 32'h0080_0000);
    send_sample(now_ms + 60, 24'sh7FFFFF, 16'hFFFF);
    send_sample(now_ms + 120, 24'sd0, 16'd0);
    now_ms += 120;
    drain_results();
    write_reg(CFG_GROUND_ALT, 32'h007F_FFFF);
    send_sample(now_ms + 60, 24'sh800000, 16'd0);
    send_sample(now_ms + 120, 24'sh7FFFFF, 16'hFFFF);
    now_ms += 120;
  endtask

  // Timestamps run across the 32-bit wrap, then jump by half the range and
  // step backward, which reads as a very long interval.
  task automatic test_time_wrap();
    send_sample(32'hFFFF_FFC0, 24'sd1000, 16'd0);
    send_sample(32'hFFFF_FFDE, 24'sd1500, 16'd0);
    send_sample(32'h0000_0010, 24'sd2000, 16'd0);
    send_sample(32'h8000_000F, -24'sd5000, 16'd0);
    send_sample(32'h7FFF_FFAB, 24'sd1000, 16'd0);
    now_ms = 32'h7FFF_FFAB;
  endtask

  // Height and velocity thresholds at their minimum so acceleration alone
  // gates the hold. The hold lasts exactly 150 ms, which must not arm, and
  // an acceleration equal to the threshold ends it.
  task automatic test_arm_hold_edge();
    drain_results();
    write_reg(CFG_GROUND_ALT, 32'd0);
    write_reg(CFG_ARM_HEIGHT, 32'h0080_0000);
    write_reg(CFG_ARM_VEL, 32'h0008_0000);
    write_reg(CFG_ARM_ACCEL, 32'd800);
    send_sample(now_ms + 60, 24'sd1000, 16'd0);
    send_sample(now_ms + 120, 24'sd1000, 16'd900);
    send_sample(now_ms + 195, 24'sd1000, 16'd900);
    send_sample(now_ms + 270, 24'sd1000, 16'd900);
    send_sample(now_ms + 280, 24'sd1000, 16'd800);
    now_ms += 280;
  endtask

  // Free-running samples with arming out of reach: random steps, some huge
  // or backward, altitudes near the last one or anywhere in range, and full
  // range accelerations.
  task automatic test_random_noise(input int n);
    logic signed [HeightW-1:0] alt;
    logic [AccelW-1:0]         acc;
    int                        r;
    alt = '0;
    drain_results();
    write_reg(CFG_GROUND_ALT, $urandom);
    write_reg(CFG_ARM_HEIGHT, $urandom);
    write_reg(CFG_ARM_VEL, $urandom);
    write_reg(CFG_ARM_ACCEL, 32'h0000_FFFF);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70) now_ms += $urandom_range(0, 120);
      else if (r < 85) now_ms += $urandom_range(0, 49);
      else if (r < 95) now_ms += $urandom_range(1000, 100000);
      else now_ms = $urandom;
      r = $urandom_range(0, 9);
      if (r < 5) alt = HeightW'(alt + (int'($urandom_range(0, 4000)) - 2000));
      else if (r < 8) alt = HeightW'($urandom);
      else alt = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      r = $urandom_range(0, 9);
      if (r < 6) acc = AccelW'($urandom_range(0, 65535));
      else if (r < 8) acc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else acc = AccelW'($urandom_range(0, 1000));
      send_sample(now_ms, alt, acc);
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the block fills up and stops taking beats until the stall ends.
  task automatic test_output_backpressure();
    sink_hold_cycles = 400;
    repeat (16) begin
      now_ms += $urandom_range(0, 120);
      send_sample(now_ms, HeightW'($urandom), AccelW'($urandom));
    end
  endtask

  // Short bursts with acceleration above its arming threshold, each spanning at most 150 ms
  // with monotonic times, and each closed by a sample at or below the
  // acceleration threshold. The hold starts and breaks over and over, yet
  // the block never arms.
  task automatic test_arm_hold_runs(input int n);
    int                        sent;
    int                        k;
    int                        span;
    int                        thr;
    logic [TimeW-1:0]          t0;
    logic signed [HeightW-1:0] alt;
    alt = '0;
    sent = 0;
    thr = $urandom_range(0, 3000);
    drain_results();
    write_reg(CFG_GROUND_ALT, 32'(int'($urandom_range(0, 2000)) - 1000));
    write_reg(CFG_ARM_HEIGHT, 32'(int'($urandom_range(0, 2000)) - 1000));
    write_reg(CFG_ARM_VEL, 32'(int'($urandom_range(0, 4000)) - 2000));
    write_reg(CFG_ARM_ACCEL, 32'(thr));
    while (sent < n) begin
      k = $urandom_range(1, 5);
      span = ($urandom_range(0, 3) == 0) ? ArmHoldTimeMs : $urandom_range(0, 150);
      now_ms += $urandom_range(1, 120);
      t0 = now_ms;
      for (int i = 0; i < k; i++) begin
        alt = HeightW'(alt + (int'($urandom_range(0, 600)) - 200));
        send_sample((k > 1) ? t0 + (span * i) / (k - 1) : t0, alt,
                    AccelW'($urandom_range(thr + 1, 65535)));
      end
      now_ms = t0 + span + $urandom_range(1, 60);
      send_sample(now_ms, alt, AccelW'($urandom_range(0, thr)));
      sent += k + 1;
    end
  endtask

  // One flight from the pad: a 3 s boost, then a ballistic coast. Depending
  // on the draw it ends by apogee detection, by the failsafe timer, or by
  // firing on the very sample that arms. The pulse runs out and the block
  // settles in done, where a few more samples follow.
  task automatic test_flight();
    flight_kind_e     kind;
    longint           ground;
    real              alt_m;
    real              vel_m;
    real              acc_net;
    real              dt_s;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] launch_t;
    logic             boost;
    int               extra;
    int               count;
    kind = flight_kind_e'($urandom_range(0, 2));
    ground = longint'($urandom_range(0, 40000)) - 20000;
    drain_results();
    write_reg(CFG_GROUND_ALT, 32'(ground));
    write_reg(CFG_ARM_HEIGHT, 32'd160);
    write_reg(CFG_ARM_VEL, 32'd320);
    write_reg(CFG_ARM_ACCEL, 32'd800);
    case (kind)
      FLIGHT_APOGEE: begin
        write_reg(CFG_EJECT_HGT, $urandom_range(4000, 20000));
        write_reg(CFG_EJECT_VEL, $urandom_range(0, 300));
        write_reg(CFG_EJECT_ACCEL, $urandom_range(2001, 65535));
        write_reg(CFG_FAILSAFE, 32'hFFFF_FFFF);
      end
      FLIGHT_FAILSAFE: begin
        write_reg(CFG_EJECT_HGT, 32'h007F_FFFF);
        write_reg(CFG_EJECT_VEL, $urandom_range(0, 300));
        write_reg(CFG_EJECT_ACCEL, $urandom_range(400, 65535));
        write_reg(CFG_FAILSAFE,
                  ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 6000));
      end
      default: begin
        write_reg(CFG_EJECT_HGT, 32'h0080_0000);
        write_reg(CFG_EJECT_VEL, 32'h0007_FFFF);
        write_reg(CFG_EJECT_ACCEL, 32'h0000_FFFF);
        write_reg(CFG_FAILSAFE, $urandom_range(0, 1) ? 32'd0 : 32'd14000);
      end
    endcase
    t = now_ms + 1000;
    launch_t = t;
    alt_m = 0.0;
    vel_m = 0.0;
    extra = 0;
    count = 0;
    // Heights in 1/16 m and velocities in 1/16 m/s; gravity is about 157.
    while (extra < 30 && count < 700) begin
      dt_s = $urandom_range(20, 120) / 1000.0;
      boost = (t - launch_t) < 32'd3000;
      acc_net = boost ? 800.0 : -157.0;
      alt_m = alt_m + vel_m * dt_s + 0.5 * acc_net * dt_s * dt_s;
      vel_m = vel_m + acc_net * dt_s;
      t = t + $rtoi(dt_s * 1000.0 + 0.5);
      send_sample(t,
                  HeightW'(ground + $rtoi(alt_m) + (int'($urandom_range(0, 16)) - 8)),
                  AccelW'(boost ? $urandom_range(1000, 2000) : $urandom_range(0, 300)));
      if (phase_q == MODE_DONE) extra++;
      count++;
    end
    now_ms = t;
  endtask

  // Receiver side: ready falls for the drawn wait after each result beat,
  // and for the whole long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      out_ready <= 1'b0;
      sink_hold_cycles--;
    end else if (sink_wait > 0) begin
      out_ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check at the rising edge, against the oldest queued status.
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_expected.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat with nothing expected, expected none, actual %p",
                 $time, out_data);
      end else begin
        want = status_expected.pop_front();
        if (out_data.pyro_on !== want.pyro_on)
          report_field("pyro_on", 32'(want.pyro_on), 32'(out_data.pyro_on));
        if (out_data.armed_flag !== want.armed_flag)
          report_field("armed_flag", 32'(want.armed_flag), 32'(out_data.armed_flag));
        if (out_data.done_res !== want.done_res)
          report_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
        if (out_data.phase !== want.phase)
          report_field("phase", 32'(want.phase), 32'(out_data.phase));
        if (out_data.velocity_est !== want.velocity_est)
          report_field("velocity_est", 32'(want.velocity_est),
                       32'(out_data.velocity_est));
      end
      sink_wait = (no_gap_run > 0) ? 0 : $urandom_range(0, 6);
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_first_sample_and_velocity();
    test_height_saturation();
    test_time_wrap();
    test_arm_hold_edge();
    test_random_noise(200);
    test_output_backpressure();
    test_arm_hold_runs(200);
    test_random_noise(60);
    // The flight has to come last: once armed, only reset returns to idle.
    test_flight();

    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && status_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
